FILE: hw/rtl/tos_pkg.sv
// shared types and constants of the timestamp outlier smoother
package tos_pkg;

	localparam int unsigned STAMP_W = 64;
	localparam int unsigned STRAT_W = 2;

	// strategy register codes; the unused code behaves like pass-through
	localparam logic [STRAT_W-1:0] STRAT_CHANGE  = 2'd0;
	localparam logic [STRAT_W-1:0] STRAT_DISCONT = 2'd1;
	localparam logic [STRAT_W-1:0] STRAT_PASS    = 2'd2;

	typedef logic signed [STAMP_W-1:0] stamp_t;

	// history kept from one sample to the next
	typedef struct packed {
		logic   seen_first;
		stamp_t previous_start;
		stamp_t last_delta;
		stamp_t average_delta;
	} tos_hist_t;

	// one result beat
	typedef struct packed {
		stamp_t out_start;
		stamp_t out_stop;
		logic   stamp_changed;
		logic   discontinuity;
		stamp_t stamp_delta;
	} tos_result_t;

endpackage

FILE: hw/rtl/tos_step.sv
// single-sample datapath: outlier test, correction and history update
module tos_step (
	input  logic [tos_pkg::STRAT_W-1:0] strategy,
	input  tos_pkg::stamp_t             sample_start,
	input  tos_pkg::stamp_t             sample_stop,
	input  tos_pkg::tos_hist_t          hist,
	output tos_pkg::tos_hist_t          hist_next,
	output tos_pkg::tos_result_t        result
);

	tos_pkg::stamp_t    delta;
	tos_pkg::stamp_t    last_adj;
	tos_pkg::stamp_t    last_quarter;
	logic signed [65:0] delta_x;
	logic signed [65:0] last_x4;
	logic               is_below;
	logic               is_above;
	logic               outlier;
	logic signed [64:0] avg_sum;
	logic signed [64:0] avg_sum_adj;
	tos_pkg::stamp_t    avg_mean;
	tos_pkg::stamp_t    repl_start;
	tos_pkg::stamp_t    repl_stop;
	logic               do_record;
	logic               do_replace;
	logic               discont;

	assign delta = sample_start - hist.previous_start;

	// last / 4 truncated toward zero: bias negatives by 3, then shift
	assign last_adj     = hist.last_delta + {62'd0, hist.last_delta[63], hist.last_delta[63]};
	assign last_quarter = {{2{last_adj[63]}}, last_adj[63:2]};
	assign is_below     = delta < last_quarter;

	// last * 4 compared exactly in 66 bits
	assign delta_x  = {{2{delta[63]}}, delta};
	assign last_x4  = {hist.last_delta, 2'b00};
	assign is_above = delta_x > last_x4;

	assign outlier = (hist.last_delta != '0) && (is_below || is_above);

	// (avg + delta) / 2 truncated toward zero, exact sum
	assign avg_sum     = {hist.average_delta[63], hist.average_delta} + {delta[63], delta};
	assign avg_sum_adj = avg_sum + {64'd0, avg_sum[64] & avg_sum[0]};
	assign avg_mean    = avg_sum_adj[64:1];

	assign repl_start = hist.previous_start + hist.average_delta;
	assign repl_stop  = hist.previous_start + {hist.average_delta[62:0], 1'b0};

	always_comb begin
		do_record  = 1'b0;
		do_replace = 1'b0;
		discont    = 1'b0;
		case (strategy)
			tos_pkg::STRAT_CHANGE: begin
				do_replace = hist.seen_first && outlier;
				do_record  = hist.seen_first && !outlier;
			end
			tos_pkg::STRAT_DISCONT: begin
				do_record = hist.seen_first;
				discont   = hist.seen_first && outlier;
			end
			default: begin
				do_record = 1'b0;
			end
		endcase
	end

	always_comb begin
		result.stamp_changed = do_replace;
		result.discontinuity = discont;
		if (do_replace) begin
			result.out_start   = repl_start;
			result.out_stop    = repl_stop;
			result.stamp_delta = hist.average_delta;
		end else begin
			result.out_start   = sample_start;
			result.out_stop    = sample_stop;
			result.stamp_delta = delta;
		end
	end

	always_comb begin
		hist_next.seen_first     = 1'b1;
		hist_next.previous_start = result.out_start;
		hist_next.last_delta     = hist.last_delta;
		hist_next.average_delta  = hist.average_delta;
		if (do_record) begin
			hist_next.last_delta    = delta;
			hist_next.average_delta = (hist.average_delta == '0) ? delta : avg_mean;
		end
	end

endmodule

FILE: hw/rtl/timestamp_outlier_smoother.sv
// top level of the timestamp outlier smoother
//
// input channel: in_valid / in_stall with sample_start and sample_stop, one
//   beat per sample; a beat is taken at an edge with in_valid high
//   and in_stall low
// output channel: out_valid / out_stall with out_start, out_stop,
//   stamp_changed, discontinuity and stamp_delta, one beat per input beat
// config channel: cfg_valid / cfg_ready with strategy; cfg_ready is always
//   high, write only while no sample is in flight
// pipeline: an input beat is held in the input register, then in the result register
// throughput: one sample per cycle unless the output stalls; the history
//   (previous start, last delta, average) is updated by one combinational datapath
//   as a sample moves from the input register to the result register
// stall: when the receiver stalls with a result held, one more sample waits
//   in the input register, then in_stall rises until the result is taken
// reset: clears strategy, history and both valid flags; the first sample
//   after reset is never tested or recorded
module timestamp_outlier_smoother (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  tos_pkg::stamp_t             sample_start,
	input  tos_pkg::stamp_t             sample_stop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output tos_pkg::stamp_t             out_start,
	output tos_pkg::stamp_t             out_stop,
	output logic                        stamp_changed,
	output logic                        discontinuity,
	output tos_pkg::stamp_t             stamp_delta,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tos_pkg::STRAT_W-1:0] strategy
);

	logic [tos_pkg::STRAT_W-1:0] strategy_q;
	logic                        valid_s1;
	tos_pkg::stamp_t             start_s1;
	tos_pkg::stamp_t             stop_s1;
	tos_pkg::tos_hist_t          hist_q;
	tos_pkg::tos_hist_t          hist_next;
	tos_pkg::tos_result_t        result;
	tos_pkg::tos_result_t        result_s2;
	logic                        valid_s2;
	logic                        advance;
	logic                        in_take;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q <= tos_pkg::STRAT_CHANGE;
		end else if (cfg_valid && cfg_ready) begin
			strategy_q <= strategy;
		end
	end

	// the held sample moves on when the result register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			start_s1 <= sample_start;
			stop_s1  <= sample_stop;
		end
	end

	tos_step u_step (
		.strategy     (strategy_q),
		.sample_start (start_s1),
		.sample_stop  (stop_s1),
		.hist         (hist_q),
		.hist_next    (hist_next),
		.result       (result)
	);

	// history follows every sample that reaches the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (advance) begin
			hist_q <= hist_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign out_start     = result_s2.out_start;
	assign out_stop      = result_s2.out_stop;
	assign stamp_changed = result_s2.stamp_changed;
	assign discontinuity = result_s2.discontinuity;
	assign stamp_delta   = result_s2.stamp_delta;

endmodule

FILE: hw/rtl/tos_checker.sv
// port-level checks for the timestamp outlier smoother, bound to the top level
module tos_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input tos_pkg::stamp_t out_start,
	input tos_pkg::stamp_t out_stop,
	input logic            stamp_changed,
	input logic            discontinuity,
	input tos_pkg::stamp_t stamp_delta
);

	// a held result stays put while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_start) && $stable(stamp_delta))
		else $error("stalled result changed");

	// only one of the two correction outcomes per beat
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(stamp_changed && discontinuity))
		else $error("stamp change and discontinuity together");

	// replaced stamps are spaced by the average, which is also the delta
	a_repl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stamp_changed |-> out_stop == tos_pkg::stamp_t'(out_start + stamp_delta))
		else $error("replaced stop does not match start plus delta");

	// input back-pressure only comes from a stalled full output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

endmodule

bind timestamp_outlier_smoother tos_checker u_tos_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.out_start     (out_start),
	.out_stop      (out_stop),
	.stamp_changed (stamp_changed),
	.discontinuity (discontinuity),
	.stamp_delta   (stamp_delta)
);

FILE: dv/timestamp_outlier_smoother_tb.sv
`timescale 1ns / 1ps
// testbench of the timestamp outlier smoother: directed and random samples checked beat by beat

// predicted corrections, kept in order of the samples taken by the block
class stamp_tracker;
	localparam int SPREAD = 4;    // a delta outside last/4 .. last*4 is an outlier
	localparam int MEAN_DIV = 2;
	localparam int MAX_LINES = 40;

	logic [tos_pkg::STRAT_W-1:0] strat;
	logic seen_first;
	tos_pkg::stamp_t prev_start;
	tos_pkg::stamp_t last_delta;
	tos_pkg::stamp_t avg_delta;
	tos_pkg::tos_result_t corrected_stamps[$];
	int mismatches;
	int beats;
	int replaced;
	int flagged;
	int per_strat[4];

	function new();
		strat = tos_pkg::STRAT_CHANGE;
		seen_first = 1'b0;
		prev_start = '0;
		last_delta = '0;
		avg_delta = '0;
		mismatches = 0;
		beats = 0;
		replaced = 0;
		flagged = 0;
		per_strat = '{default: 0};
	endfunction

	function bit busy();
		return corrected_stamps.size() != 0;
	endfunction

	// exact bounds: the product is formed wide so it never wraps
	function bit is_outlier(tos_pkg::stamp_t l, tos_pkg::stamp_t d);
		logic signed [tos_pkg::STAMP_W+2:0] l_wide;
		logic signed [tos_pkg::STAMP_W+2:0] d_wide;
		if (l == 0)
			return 1'b0;
		l_wide = {{3{l[tos_pkg::STAMP_W-1]}}, l};
		l_wide = l_wide * SPREAD;
		d_wide = {{3{d[tos_pkg::STAMP_W-1]}}, d};
		return (d < l / SPREAD) || (d_wide > l_wide);
	endfunction

	// a delta seeds the average while the average is zero, else it is averaged in
	function void record_delta(tos_pkg::stamp_t d);
		logic signed [tos_pkg::STAMP_W:0] sum;
		last_delta = d;
		if (avg_delta == 0) begin
			avg_delta = d;
		end else begin
			sum = {avg_delta[tos_pkg::STAMP_W-1], avg_delta};
			sum = (sum + d) / MEAN_DIV;
			avg_delta = sum[tos_pkg::STAMP_W-1:0];
		end
	endfunction

	function void correct_sample(tos_pkg::stamp_t s_start, tos_pkg::stamp_t s_stop);
		tos_pkg::tos_result_t r;
		tos_pkg::stamp_t d;
		bit outl;
		d = s_start - prev_start;
		r.stamp_changed = 1'b0;
		r.discontinuity = 1'b0;
		per_strat[strat]++;
		if (seen_first) begin
			outl = is_outlier(last_delta, d);
			if (strat == tos_pkg::STRAT_DISCONT) begin
				r.discontinuity = outl;
				flagged += int'(outl);
				record_delta(d);
			end else if (strat == tos_pkg::STRAT_CHANGE) begin
				if (outl) begin
					// stop of the sample is dropped, both stamps follow the average
					s_start = prev_start + avg_delta;
					s_stop = s_start + avg_delta;
					d = s_start - prev_start;
					r.stamp_changed = 1'b1;
					replaced++;
				end else begin
					record_delta(d);
				end
			end
		end
		prev_start = s_start;
		seen_first = 1'b1;
		r.out_start = s_start;
		r.out_stop = s_stop;
		r.stamp_delta = d;
		corrected_stamps.push_back(r);
	endfunction

	task report(string what);
		if (mismatches < MAX_LINES)
			$display("mismatch at result beat %0d: %s", beats, what);
		mismatches++;
	endtask

	task check_field(string name, tos_pkg::stamp_t got, tos_pkg::stamp_t want);
		if (got !== want)
			report($sformatf("%s is %0d, predicted %0d", name, got, want));
	endtask

	task check_beat(tos_pkg::stamp_t o_start, tos_pkg::stamp_t o_stop, logic o_changed,
			logic o_disc, tos_pkg::stamp_t o_delta);
		tos_pkg::tos_result_t want;
		beats++;
		if (corrected_stamps.size() == 0) begin
			report($sformatf("beat with out_start %0d and no sample outstanding", o_start));
			return;
		end
		want = corrected_stamps.pop_front();
		check_field("out_start", o_start, want.out_start);
		check_field("out_stop", o_stop, want.out_stop);
		check_field("stamp_changed", tos_pkg::stamp_t'(o_changed),
			tos_pkg::stamp_t'(want.stamp_changed));
		check_field("discontinuity", tos_pkg::stamp_t'(o_disc),
			tos_pkg::stamp_t'(want.discontinuity));
		check_field("stamp_delta", o_delta, want.stamp_delta);
	endtask
endclass

module timestamp_outlier_smoother_tb;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 210;
	localparam int PHASES = 8;
	localparam logic [tos_pkg::STRAT_W-1:0] STRAT_SPARE = 2'd3;
	localparam tos_pkg::stamp_t STAMP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam tos_pkg::stamp_t STAMP_MIN = 64'sh8000_0000_0000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	tos_pkg::stamp_t sample_start = '0;
	tos_pkg::stamp_t sample_stop = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	tos_pkg::stamp_t out_start;
	tos_pkg::stamp_t out_stop;
	logic stamp_changed;
	logic discontinuity;
	tos_pkg::stamp_t stamp_delta;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tos_pkg::STRAT_W-1:0] strategy = tos_pkg::STRAT_CHANGE;

	logic [tos_pkg::STRAT_W-1:0] phase_plan [PHASES] = '{tos_pkg::STRAT_CHANGE,
		tos_pkg::STRAT_DISCONT, tos_pkg::STRAT_PASS, tos_pkg::STRAT_CHANGE,
		tos_pkg::STRAT_DISCONT, STRAT_SPARE, tos_pkg::STRAT_CHANGE, tos_pkg::STRAT_DISCONT};

	bit gap_mix = 1'b1;
	bit stall_mix = 1'b1;
	tos_pkg::stamp_t stream_base = '0;
	int cycles = 0;
	int stall_left = 0;
	int run_left = 0;
	stamp_tracker trk = new();

	timestamp_outlier_smoother dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample_start  (sample_start),
		.sample_stop   (sample_stop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_start     (out_start),
		.out_stop      (out_stop),
		.stamp_changed (stamp_changed),
		.discontinuity (discontinuity),
		.stamp_delta   (stamp_delta),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.strategy      (strategy)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				trk.corrected_stamps.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// all three channels sampled with the values from before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				trk.check_beat(out_start, out_stop, stamp_changed, discontinuity, stamp_delta);
			if (in_valid && !in_stall)
				trk.correct_sample(sample_start, sample_stop);
			if (cfg_valid && cfg_ready)
				trk.strat = strategy;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver back-pressure: stall bursts separated by free runs, now and then a long one
	always @(posedge clk) begin
		if (!stall_mix) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (run_left > 0) begin
			out_stall <= 1'b0;
			run_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap();
			run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200)
				: $urandom_range(0, 12);
		end
	end

	function automatic tos_pkg::stamp_t rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic tos_pkg::stamp_t pick_delta();
		tos_pkg::stamp_t d;
		int r;
		r = $urandom_range(0, 99);
		d = rand64();
		if (r < 40) begin
			d = tos_pkg::stamp_t'($urandom_range(1, 1 << 20));
		end else if (r < 55) begin
			d = tos_pkg::stamp_t'($urandom_range(0, 8));
		end else if (r < 70) begin
			// four times this no longer fits in 64 bits
			d[63:62] = 2'b00;
			d[61] = 1'b1;
		end else if (r < 85) begin
			d = -tos_pkg::stamp_t'($urandom_range(1, 1 << 20));
		end
		return d;
	endfunction

	// one beat; valid stays up when the next beat follows with no gap
	task automatic send_sample(tos_pkg::stamp_t s_start, tos_pkg::stamp_t s_stop);
		int g;
		g = gap_mix ? pick_gap() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_start <= s_start;
		sample_stop <= s_stop;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (trk.busy())
			@(posedge clk);
	endtask

	task automatic write_strategy(logic [tos_pkg::STRAT_W-1:0] code);
		wait_drained();
		cfg_valid <= 1'b1;
		strategy <= code;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly steady streams with jitter, single spikes and repeats; some raw noise
	task automatic run_phase(int count, bit drain_pauses);
		tos_pkg::stamp_t d;
		tos_pkg::stamp_t s;
		tos_pkg::stamp_t dur;
		int seg;
		int k;
		int r;
		int j;
		k = 0;
		while (k < count) begin
			d = pick_delta();
			seg = $urandom_range(6, 48);
			while (seg > 0 && k < count) begin
				r = $urandom_range(0, 99);
				j = int'($urandom_range(0, 2)) - 1;
				stream_base = stream_base + d + (d >>> 5) * tos_pkg::stamp_t'(j);
				if (r < 8) begin
					send_sample(rand64(), rand64());
				end else begin
					s = stream_base;
					if (r < 16)
						s = stream_base + d * tos_pkg::stamp_t'($urandom_range(4, 9));
					else if (r < 22)
						s = stream_base - d + (d >>> 3);
					else if (r < 24)
						s = stream_base - d;
					dur = d + tos_pkg::stamp_t'($urandom_range(0, 3));
					send_sample(s, s + dur);
				end
				if (drain_pauses && (k % 64) == 63)
					wait_drained();
				seg--;
				k++;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// strategy still at its reset value: change stamp
		send_sample(64'sd1000, 64'sd1100);     // first sample, never tested
		send_sample(64'sd2000, 64'sd2100);     // last delta zero, never an outlier
		send_sample(64'sd3000, 64'sd3100);
		send_sample(64'sd3100, 64'sd3200);     // below a quarter of the last delta
		send_sample(64'sd20000, 64'sd20100);   // above four times the last delta
		send_sample(64'sd9000, 64'sd9500);     // exactly four times
		send_sample(64'sd10000, 64'sd10400);   // exactly a quarter
		send_sample(STAMP_MAX, STAMP_MIN);
		send_sample(STAMP_MIN, STAMP_MAX);

		write_strategy(tos_pkg::STRAT_DISCONT);
		send_sample(64'sd0, -64'sd1);
		send_sample(STAMP_MIN, 64'sd1);          // delta is the most negative value
		send_sample(STAMP_MIN + 64'sd5, 64'sd0);
		send_sample(64'sh4000_0000_0000_0000, 64'sd7);
		send_sample(STAMP_MAX, 64'sd0);
		send_sample(-64'sd3, -64'sd2);
		send_sample(-64'sd14, 64'sd0);           // odd negative sums in the average
		send_sample(-64'sd21, 64'sd0);

		write_strategy(tos_pkg::STRAT_PASS);
		send_sample(64'sd5, 64'sd5);
		send_sample(STAMP_MAX, STAMP_MAX);

		write_strategy(STRAT_SPARE);
		send_sample(-64'sd1, -64'sd1);
		send_sample(64'sd0, 64'sd0);

		for (int i = 0; i < PHASES; i++) begin
			write_strategy(phase_plan[i]);
			gap_mix = (i != 3);
			stall_mix = (i != 3);
			run_phase(PHASE_ITEMS, i == 1);
		end
		gap_mix = 1'b1;
		stall_mix = 1'b1;

		wait_drained();
		repeat (4) @(posedge clk);

		$display("covered %0d samples: %0d change stamp, %0d discontinuity,",
			trk.beats, trk.per_strat[tos_pkg::STRAT_CHANGE],
			trk.per_strat[tos_pkg::STRAT_DISCONT]);
		$display("  %0d pass, %0d spare code; %0d replaced, %0d flagged, %0d mismatches",
			trk.per_strat[tos_pkg::STRAT_PASS], trk.per_strat[STRAT_SPARE],
			trk.replaced, trk.flagged, trk.mismatches);
		if (trk.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

FILE: sim.f
hw/rtl/tos_pkg.sv
hw/rtl/tos_step.sv
hw/rtl/timestamp_outlier_smoother.sv
hw/rtl/tos_checker.sv
dv/timestamp_outlier_smoother_tb.sv
